### src/ssmt_pkg.sv
// ----------------------------------------------------------------------------
// ssmt_pkg
// Shared types and constants for the sorted sparse memory table.
// ----------------------------------------------------------------------------
`default_nettype none
package ssmt_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrBits   = 32;
  localparam int unsigned KeyWidth   = 32;   // width of the address field on the port

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input word, start search
    logic srch_step;   // one binary search step
    logic rd_lb;       // issue memory read at lower bound
    logic chk_hit;     // evaluate hit from read data
    logic shift_up;    // one insert shift step
    logic shift_dn;    // one delete shift step
    logic wr_new;      // write new entry at lower bound
    logic wr_byte;     // overwrite byte at lower bound
    logic cnt_inc;
    logic cnt_dec;
    logic run_rd;      // issue run read at scan index
    logic run_chk;     // compare run read data
    logic set_out;     // load output register
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic srch_done;
    logic hit;
    logic full;
    logic shift_done;
    logic lb_at_end;
    logic run_more;    // next entry continues run
    logic wr_busy;     // shifted word still being written this cycle
  } stat_t;
endpackage
`default_nettype wire

### src/ssmt_datapath.sv
// ----------------------------------------------------------------------------
// ssmt_datapath
// Entry memory, search bounds, shift pointer, run scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ssmt_datapath #(
  parameter int unsigned TABLE_DEPTH = ssmt_pkg::TableDepth,
  parameter int unsigned ADDR_BITS   = ssmt_pkg::AddrBits
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ssmt_pkg::ctrl_t          ctrl,
  output      ssmt_pkg::stat_t          stat,
  input  wire logic [1:0]               in_cmd,
  input  wire logic [ssmt_pkg::KeyWidth-1:0] in_addr,
  input  wire logic [7:0]               in_data,
  output      logic [1:0]               res_status,
  output      logic [7:0]               res_data,
  output      logic [10:0]              res_first,
  output      logic [9:0]               res_last,
  output      logic [10:0]              res_used
);
  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned EW = ADDR_BITS + 8;

  logic [EW-1:0]        mem [TABLE_DEPTH];
  logic [EW-1:0]        rdata;
  logic [IW-1:0]        raddr;
  logic                 re;
  logic [IW-1:0]        waddr;
  logic [EW-1:0]        wdata;
  logic                 we;

  logic [1:0]           cmd;
  logic [ADDR_BITS-1:0] key;
  logic [7:0]           byte_in;
  logic [CW-1:0]        count;
  logic [CW-1:0]        lo, hi, ptr;
  logic                 hit;
  logic                 was_full;
  logic [CW-1:0]        mid;
  logic [ADDR_BITS-1:0] prev;
  logic [ADDR_BITS-1:0] rkey;

  assign mid  = lo + ((hi - lo) >> 1);
  assign rkey = rdata[EW-1:8];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // read port select
  always_comb begin
    re    = 1'b1;
    raddr = mid[IW-1:0];
    if (ctrl.rd_lb) raddr = lo[IW-1:0];
    else if (ctrl.shift_up) raddr = ptr[IW-1:0] - IW'(1);
    else if (ctrl.shift_dn || ctrl.run_rd) raddr = ptr[IW-1:0];
  end

  // write port select; shifts write the word read on the previous step
  logic             sh_wr;
  logic [IW-1:0]    sh_addr;
  always_ff @(posedge clk) begin
    if (rst) sh_wr <= 1'b0;
    else     sh_wr <= ctrl.shift_up || ctrl.shift_dn;
    sh_addr <= ctrl.shift_up ? ptr[IW-1:0] : ptr[IW-1:0] - IW'(1);
  end

  always_comb begin
    we    = 1'b0;
    waddr = lo[IW-1:0];
    wdata = {key, byte_in};
    priority if (sh_wr) begin
      we    = 1'b1;
      waddr = sh_addr;
      wdata = rdata;
    end else if (ctrl.wr_new) begin
      we = 1'b1;
    end else if (ctrl.wr_byte) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (ctrl.cnt_inc) count <= count + CW'(1);
      if (ctrl.cnt_dec) count <= count - CW'(1);
    end
  end

  // 'srch_step' compares mem[mid] read on the previous cycle
  logic [CW-1:0] mid_q;
  logic          cmp_pend;
  always_ff @(posedge clk) begin
    if (rst) cmp_pend <= 1'b0;
    else     cmp_pend <= ctrl.srch_step && (lo < hi) && !cmp_pend;
    mid_q <= mid;
    if (ctrl.load) begin
      cmd     <= in_cmd;
      key     <= ADDR_BITS'(in_addr);
      byte_in <= in_data;
      lo      <= '0;
      hi      <= count;
    end else if (ctrl.srch_step && cmp_pend) begin
      if (rkey < key) lo <= mid_q + CW'(1);
      else            hi <= mid_q;
    end
    if (ctrl.chk_hit) begin
      hit      <= (lo < count) && (rkey == key);
      was_full <= (count == CW'(TABLE_DEPTH));
      ptr      <= (cmd == ssmt_pkg::CMD_WRITE) ? count : lo + CW'(1);
    end else if (ctrl.shift_up) begin
      ptr <= ptr - CW'(1);
    end else if (ctrl.shift_dn || ctrl.run_chk) begin
      ptr <= ptr + CW'(1);
    end
    if (ctrl.chk_hit) prev <= rkey;
    else if (ctrl.run_chk) prev <= rkey;
  end

  assign stat.srch_done  = !(lo < hi) && !cmp_pend;
  assign stat.hit        = hit;
  assign stat.full       = (count == CW'(TABLE_DEPTH));
  assign stat.shift_done = (cmd == ssmt_pkg::CMD_WRITE) ? (ptr <= lo) : (ptr >= count);
  assign stat.lb_at_end  = (lo >= count);
  assign stat.run_more   = (ptr < count) && (rkey == prev + ADDR_BITS'(1));
  assign stat.wr_busy    = sh_wr;

  always_ff @(posedge clk) begin
    if (ctrl.set_out) begin
      res_data  <= '0;
      res_last  <= '0;
      res_first <= 11'(lo);
      res_used  <= 11'(count);
      res_status <= ssmt_pkg::ST_OK;
      unique case (ssmt_pkg::cmd_t'(cmd))
        ssmt_pkg::CMD_WRITE:
          if (!hit && was_full) res_status <= ssmt_pkg::ST_FULL;
        ssmt_pkg::CMD_DELETE:
          if (!hit) res_status <= ssmt_pkg::ST_NOT_FOUND;
        ssmt_pkg::CMD_READ:
          if (hit) res_data <= rdata[7:0];
          else     res_status <= ssmt_pkg::ST_NOT_FOUND;
        ssmt_pkg::CMD_RUN:
          if (lo >= count) res_status <= ssmt_pkg::ST_NOT_FOUND;
          else             res_last <= 10'(ptr - CW'(1));
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/ssmt_ctrl.sv
// ----------------------------------------------------------------------------
// ssmt_ctrl
// Command sequencer: search, hit check, shift, run scan, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module ssmt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_fire,
  input  wire logic [1:0]      in_cmd,
  input  wire logic            out_fire,
  output      logic            in_ready,
  output      logic            out_valid,
  output      ssmt_pkg::ctrl_t ctrl,
  input  wire ssmt_pkg::stat_t stat
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SRCH  = 10'b0000000010,
    S_RDLB  = 10'b0000000100,
    S_HIT   = 10'b0000001000,
    S_UP    = 10'b0000010000,
    S_DN    = 10'b0000100000,
    S_RUNRD = 10'b0001000000,
    S_RUNCK = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_HOLD  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   [1:0] cmd;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
    if (in_fire) cmd <= in_cmd;
  end

  // S_HOLD: result shown; a new word may be taken once the old one has left
  assign out_valid = (state == S_HOLD);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctrl = '0;
    unique case (state)
      S_IDLE: if (in_fire) begin
        ctrl.load  = 1'b1;
        state_next = S_SRCH;
      end
      S_SRCH: begin
        ctrl.srch_step = 1'b1;
        if (stat.srch_done) state_next = S_RDLB;
      end
      S_RDLB: begin
        ctrl.rd_lb = 1'b1;
        state_next = S_HIT;
      end
      S_HIT: begin
        ctrl.chk_hit = 1'b1;
        state_next = S_OUT;
        unique case (ssmt_pkg::cmd_t'(cmd))
          ssmt_pkg::CMD_WRITE:  state_next = S_UP;
          ssmt_pkg::CMD_DELETE: state_next = S_DN;
          ssmt_pkg::CMD_RUN:    state_next = S_RUNRD;
          default:              state_next = S_OUT;
        endcase
      end
      S_UP: begin
        if (stat.hit) begin
          ctrl.wr_byte = 1'b1;
          state_next   = S_OUT;
        end else if (stat.full) begin
          state_next = S_OUT;
        end else if (stat.shift_done) begin
          // last shifted word owns the write port this cycle; wait until it is free
          if (!stat.wr_busy) begin
            ctrl.wr_new  = 1'b1;
            ctrl.cnt_inc = 1'b1;
            state_next   = S_OUT;
          end
        end else begin
          ctrl.shift_up = 1'b1;
        end
      end
      S_DN: begin
        if (!stat.hit) begin
          state_next = S_OUT;
        end else if (stat.shift_done) begin
          ctrl.cnt_dec = 1'b1;
          state_next   = S_OUT;
        end else begin
          ctrl.shift_dn = 1'b1;
        end
      end
      S_RUNRD: begin
        ctrl.run_rd = 1'b1;
        state_next  = stat.lb_at_end ? S_OUT : S_RUNCK;
      end
      S_RUNCK: begin
        if (stat.run_more) begin
          ctrl.run_chk = 1'b1;
          state_next   = S_RUNRD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        ctrl.set_out = 1'b1;
        state_next   = S_HOLD;
      end
      S_HOLD: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/sorted_sparse_memory_table_top.sv
// ----------------------------------------------------------------------------
// sorted_sparse_memory_table_top
// Sorted (address, byte) table with binary search, insert, delete and runs.
// ----------------------------------------------------------------------------
// One command word at a time. Each word takes a binary search in which each
// halving of the used range is one memory read and one compare, a hit check
// (S_RDLB, S_HIT), then: a write insert or delete shifts entries one per
// cycle through the entry memory (one read port, one write port), and an
// insert that shifted waits until the last shifted word is written before
// placing the new entry; a run query scans each run entry with a read state
// and a check state. Reads and overwrites finish after the search and hit
// check. No clearing pass: only entries below the fill count are ever used.
`default_nettype none
module sorted_sparse_memory_table_top #(
  parameter int unsigned TABLE_DEPTH = ssmt_pkg::TableDepth,
  parameter int unsigned ADDR_BITS   = ssmt_pkg::AddrBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [47:0] s_tdata,  // cmd[1:0], address[33:2], data_in[41:34], zero
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [47:0] m_tdata   // status[1:0], data_out[9:2], first_index[20:10],
                                     // last_index[30:21], entries_used[41:31], zero
);
  ssmt_pkg::ctrl_t ctrl;
  ssmt_pkg::stat_t stat;
  logic [1:0]  res_status;
  logic [7:0]  res_data;
  logic [10:0] res_first;
  logic [9:0]  res_last;
  logic [10:0] res_used;

  ssmt_ctrl u_ctrl (
    .clk, .rst,
    .in_fire  (s_tvalid && s_tready),
    .in_cmd   (s_tdata[1:0]),
    .out_fire (m_tvalid && m_tready),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .ctrl, .stat
  );

  ssmt_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst, .ctrl, .stat,
    .in_cmd  (s_tdata[1:0]),
    .in_addr (s_tdata[33:2]),
    .in_data (s_tdata[41:34]),
    .res_status, .res_data, .res_first, .res_last, .res_used
  );

  assign m_tdata = {6'd0, res_used, res_last, res_first, res_data, res_status};

  // result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");
  // never take a word while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input and output both open");
  // fill count never passes the depth
  a_used: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_used <= 11'(TABLE_DEPTH)) else $error("count overflow");
endmodule
`default_nettype wire

### tb/tb_sorted_sparse_memory_table_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_sparse_memory_table_top
// Self-checking bench for the sorted sparse memory table.
// ----------------------------------------------------------------------------
// Command words are streamed in, and an internal model of the sorted table
// predicts each reply word. Reply words are checked field by field in order.
// Directed part: empty-table cases, extreme keys and bytes, misses, hits,
// an ascending burst with a run query over it, then a drain back to empty.
// Random part: mostly keys from a narrow sliding window, so that hits and
// runs are common, plus wide and extreme keys. Both sides idle at random,
// and the reply side holds off once for a long stretch.
`default_nettype none

// Reply word fields, unpacked
typedef struct packed {
  ssmt_pkg::status_t status;
  logic [7:0]  data_out;
  logic [10:0] first_index;
  logic [9:0]  last_index;
  logic [10:0] entries_used;
} reply_t;

class table_tracker;
  logic [31:0] key_tab[ssmt_pkg::TableDepth];
  logic [7:0]  byte_tab[ssmt_pkg::TableDepth];
  int unsigned used;
  reply_t      pending_replies[$];
  int unsigned mismatches;

  function new();
    used = 0;
    mismatches = 0;
  endfunction

  function int unsigned lower_bound(logic [31:0] key);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = used;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_tab[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one accepted command to the table and queue its reply
  function void note_command(ssmt_pkg::cmd_t cmd, logic [31:0] key, logic [7:0] din);
    int unsigned idx, j;
    bit          hit;
    reply_t      r;
    idx = lower_bound(key);
    hit = (idx < used) && (key_tab[idx] == key);
    r = '0;
    r.status = ssmt_pkg::ST_OK;
    r.first_index = idx[10:0];
    case (cmd)
      ssmt_pkg::CMD_WRITE: begin
        if (hit) begin
          byte_tab[idx] = din;
        end else if (used >= ssmt_pkg::TableDepth) begin
          r.status = ssmt_pkg::ST_FULL;
        end else begin
          for (j = used; j > idx; j--) begin
            key_tab[j] = key_tab[j-1];
            byte_tab[j] = byte_tab[j-1];
          end
          key_tab[idx] = key;
          byte_tab[idx] = din;
          used++;
        end
      end
      ssmt_pkg::CMD_DELETE: begin
        if (hit) begin
          for (j = idx; j + 1 < used; j++) begin
            key_tab[j] = key_tab[j+1];
            byte_tab[j] = byte_tab[j+1];
          end
          used--;
        end else begin
          r.status = ssmt_pkg::ST_NOT_FOUND;
        end
      end
      ssmt_pkg::CMD_READ: begin
        if (hit) r.data_out = byte_tab[idx];
        else r.status = ssmt_pkg::ST_NOT_FOUND;
      end
      default: begin
        if (used == 0) begin
          r.status = ssmt_pkg::ST_NOT_FOUND;
          r.first_index = '0;
        end else if (idx >= used) begin
          r.status = ssmt_pkg::ST_NOT_FOUND;
          r.first_index = used[10:0];
        end else begin
          // run grows while each next key is the previous plus one
          j = idx + 1;
          while (j < used && key_tab[j] == key_tab[j-1] + 32'd1) j++;
          r.last_index = 10'(j - 1);
        end
      end
    endcase
    r.entries_used = used[10:0];
    pending_replies.push_back(r);
  endfunction

  function void check_reply(logic [47:0] word);
    reply_t got, exp;
    bit     bad;
    got.status       = ssmt_pkg::status_t'(word[1:0]);
    got.data_out     = word[9:2];
    got.first_index  = word[20:10];
    got.last_index   = word[30:21];
    got.entries_used = word[41:31];
    if (pending_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected reply word %h", word);
      return;
    end
    exp = pending_replies.pop_front();
    bad = (got.status !== exp.status) || (got.data_out !== exp.data_out) ||
          (got.first_index !== exp.first_index) ||
          (got.last_index !== exp.last_index) ||
          (got.entries_used !== exp.entries_used);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"ERROR: reply st/data/first/last/used exp %0d/%h/%0d/%0d/%0d",
                  " got %0d/%h/%0d/%0d/%0d"},
                 exp.status, exp.data_out, exp.first_index, exp.last_index,
                 exp.entries_used, got.status, got.data_out, got.first_index,
                 got.last_index, got.entries_used);
    end
  endfunction
endclass

module tb_sorted_sparse_memory_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned BurstLen   = 48;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  table_tracker tracker = new();
  int unsigned  cycles = 0;
  int unsigned  replies = 0;
  bit           steady = 1'b0;   // no idling on either side while set
  bit           held = 1'b0;

  sorted_sparse_memory_table_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Reply side: random ready, one long hold-off once traffic is flowing
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && replies == 40) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_tready <= steady || ($urandom_range(99) >= 9);
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        tracker.check_reply(m_tdata);
        replies++;
      end
    end
  end

  // Offer one command word; return once it is taken
  task automatic send_cmd(ssmt_pkg::cmd_t cmd, logic [31:0] key, logic [7:0] din);
    if (!steady && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, din, key, cmd};
    do @(posedge clk); while (!s_tready);
    tracker.note_command(cmd, key, din);
  endtask

  function automatic logic [31:0] pick_key(logic [31:0] win);
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return win + $urandom_range(47);
    if (p < 90) return $urandom;
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(3);
    endcase
  endfunction

  initial begin
    logic [31:0]    win;
    int unsigned    p, i;
    ssmt_pkg::cmd_t c;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table cases
    send_cmd(ssmt_pkg::CMD_RUN, 32'h0000_1234, 8'h00);
    send_cmd(ssmt_pkg::CMD_READ, 32'h0000_1234, 8'hFF);
    send_cmd(ssmt_pkg::CMD_DELETE, 32'hFFFF_FFFF, 8'h00);
    // Extreme keys and bytes, overwrite, hits and misses
    send_cmd(ssmt_pkg::CMD_WRITE, 32'h0000_0000, 8'hFF);
    send_cmd(ssmt_pkg::CMD_WRITE, 32'hFFFF_FFFF, 8'h00);
    send_cmd(ssmt_pkg::CMD_WRITE, 32'h0000_0001, 8'hA5);
    send_cmd(ssmt_pkg::CMD_WRITE, 32'h0000_0000, 8'h5A);
    send_cmd(ssmt_pkg::CMD_READ, 32'h0000_0000, 8'h00);
    send_cmd(ssmt_pkg::CMD_READ, 32'hFFFF_FFFF, 8'hFF);
    send_cmd(ssmt_pkg::CMD_READ, 32'h0000_0002, 8'h00);
    send_cmd(ssmt_pkg::CMD_RUN, 32'h0000_0000, 8'h00);   // run of two
    send_cmd(ssmt_pkg::CMD_RUN, 32'h0000_0002, 8'h00);   // absent key, run still hits
    send_cmd(ssmt_pkg::CMD_WRITE, 32'h8000_0000, 8'h11);
    send_cmd(ssmt_pkg::CMD_RUN, 32'hFFFF_FFFF, 8'h00);
    send_cmd(ssmt_pkg::CMD_DELETE, 32'h0000_0005, 8'h00);
    send_cmd(ssmt_pkg::CMD_DELETE, 32'h0000_0000, 8'h00);
    send_cmd(ssmt_pkg::CMD_DELETE, 32'h8000_0000, 8'h00);
    send_cmd(ssmt_pkg::CMD_DELETE, 32'h0000_0001, 8'h00);
    send_cmd(ssmt_pkg::CMD_RUN, 32'hFFFF_FFFF, 8'h00);   // single entry run
    send_cmd(ssmt_pkg::CMD_DELETE, 32'hFFFF_FFFF, 8'h00);

    // Ascending burst (appends, no shifting), no random idling
    steady = 1'b1;
    for (i = 0; i < BurstLen; i++)
      send_cmd(ssmt_pkg::CMD_WRITE, 32'h0001_0000 + i, 8'($urandom));
    steady = 1'b0;
    send_cmd(ssmt_pkg::CMD_RUN, 32'h0001_0000, 8'h00);   // whole burst is one run
    send_cmd(ssmt_pkg::CMD_READ, 32'h0001_0020, 8'h00);
    // Drain from the top end so no entry moves
    for (i = BurstLen; i > 0; i--)
      send_cmd(ssmt_pkg::CMD_DELETE, 32'h0001_0000 + i - 1, 8'h00);

    // Random commands over a sliding key window
    win = $urandom;
    for (i = 0; i < 450; i++) begin
      if (i % 100 == 0) win = $urandom;
      steady = (i >= 200 && i < 280);
      p = $urandom_range(99);
      c = (p < 35) ? ssmt_pkg::CMD_WRITE : (p < 55) ? ssmt_pkg::CMD_DELETE :
          (p < 80) ? ssmt_pkg::CMD_READ : ssmt_pkg::CMD_RUN;
      send_cmd(c, pick_key(win), 8'($urandom));
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;

    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

`default_nettype wire
